// File: rtl/core/gbbw_pkg.sv
// ----------------------------------------------------------------------------
// gbbw_pkg
// Shared types and constants of the gradient band blend weights block.
// ----------------------------------------------------------------------------
package gbbw_pkg;

  localparam int unsigned WEIGHT_BITS = 17;
  localparam logic [WEIGHT_BITS-1:0] ONE_Q16 = 17'h10000;
  localparam int unsigned DIV_STEPS = 16;

  // op field codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_SAMPLE_COUNT  = 1'b0;
  localparam logic REG_CENTER_ENABLE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OUTER,
    ST_PAIR,
    ST_MUL,
    ST_PSET,
    ST_PDIV,
    ST_FIN,
    ST_NSCAN,
    ST_NRD,
    ST_NDIV,
    ST_ESCAN,
    ST_EOUT,
    ST_EONE,
    ST_EEMPTY
  } gbbw_state_t;

  typedef struct packed {
    logic [2:0]             sample_index;
    logic                   is_center;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   is_max;
    logic                   empty_res;
    logic                   last;
  } gbbw_res_t;

endpackage

// File: rtl/core/gbbw_in_if.sv
// ----------------------------------------------------------------------------
// gbbw_in_if
// Input channel: table writes and blend point queries.
// ----------------------------------------------------------------------------
interface gbbw_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [2:0]                   entry_index;
  logic signed [COORD_BITS-1:0] entry_x;
  logic signed [COORD_BITS-1:0] entry_y;
  logic                         entry_valid;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;

  modport source (
    output valid, op, entry_index, entry_x, entry_y, entry_valid, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, op, entry_index, entry_x, entry_y, entry_valid, query_x, query_y,
    output ready
  );
endinterface

// File: rtl/core/gbbw_out_if.sv
// ----------------------------------------------------------------------------
// gbbw_out_if
// Result channel: one normalized weight per transaction.
// ----------------------------------------------------------------------------
interface gbbw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  sample_index;
  logic        is_center;
  logic [16:0] weight;
  logic        is_max;
  logic        empty_res;
  logic        last;

  modport source (
    output valid, sample_index, is_center, weight, is_max, empty_res, last,
    input  ready
  );
  modport sink (
    input  valid, sample_index, is_center, weight, is_max, empty_res, last,
    output ready
  );
endinterface

// File: rtl/core/gradient_band_blend_weights_core.sv
// ----------------------------------------------------------------------------
// gradient_band_blend_weights_core
// Gradient band blend weights for a 2D sample table, one shared multiplier
// and one shared restoring divider under a small sequencer.
//
//   channel | dir | handshake           | contents
//   in_ch   | in  | valid/ready         | op, entry fields, query point
//   out_ch  | out | valid/ready         | index, center, weight, flags
//   apb     | in  | psel/penable/pready | sample_count, center_enable
//
// A table write is accepted only while idle. A query with S = sample_count +
// center_enable slots sweeps every pair of slots: pair fetch, 5 multiplier
// steps, setup and, unless the pair is skipped, 16 divider steps per pair.
// Normalization then uses the same divider for each weighted slot, and each
// result is sent in turn. in_ch.ready is high only between queries.
// A stalled result holds in the output register; reset clears the table,
// the control registers and the output valid flag.
// ----------------------------------------------------------------------------
module gradient_band_blend_weights_core #(
  parameter int MAX_SAMPLES = 8,
  parameter int COORD_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  gbbw_in_if.sink     in_ch,
  gbbw_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gbbw_pkg::*;

  localparam int IW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SLOTS = MAX_SAMPLES + 1;
  localparam int SLW   = $clog2(SLOTS);
  localparam int SW    = $clog2(MAX_SAMPLES + 2);
  localparam int CW    = COORD_BITS;
  localparam int PW    = 2 * CW + 2;
  localparam int AW    = 2 * CW + 4;
  localparam int SUMW  = $clog2(SLOTS * 65536 + 1);
  localparam int DW    = (2 * CW + 3 > SUMW + 1) ? 2 * CW + 3 : SUMW + 1;

  gbbw_state_t state_r, state_nxt;

  logic signed [CW-1:0] tab_x_r [MAX_SAMPLES];
  logic signed [CW-1:0] tab_y_r [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] tab_v_r;
  logic [3:0] samp_cnt_r;
  logic       ctr_en_r;

  logic [SW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, n_r, n_nxt, end_r, end_nxt;
  logic signed [CW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [CW-1:0] pix_r, pix_nxt, piy_r, piy_nxt;
  logic signed [CW:0] qx_r, qx_nxt, qy_r, qy_nxt, dx_r, dx_nxt, dy_r, dy_nxt;
  logic [2:0] ms_r, ms_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [AW-1:0] len_r, len_nxt, proj_r, proj_nxt;
  logic [16:0] w_r, w_nxt;
  logic [SUMW-1:0] sum_r, sum_nxt;
  logic [SLOTS-1:0] listed_r, listed_nxt;
  logic [DW-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [16:0] q_r, q_nxt;
  logic [3:0] dcnt_r, dcnt_nxt;
  logic [SLW-1:0] best_r, best_nxt;
  logic best_v_r, best_v_nxt;
  logic [16:0] best_w_r, best_w_nxt;
  gbbw_res_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [16:0] raw_mem [SLOTS];
  logic [16:0] rd_r;
  logic        raw_we;
  logic [SLW-1:0] raw_wa;
  logic [16:0] raw_wd;

  // query slot count
  logic [SW-1:0] n_calc;
  assign n_calc = (7'(samp_cnt_r) > 7'(MAX_SAMPLES)) ? SW'(MAX_SAMPLES) : SW'(samp_cnt_r);

  // single table read port, slot at or above n is the origin
  logic [SW-1:0] tab_addr;
  logic          pos_in;
  logic signed [CW-1:0] pos_x, pos_y;
  logic          pos_v;
  assign tab_addr = (state_r == ST_OUTER) ? i_r : j_r;
  assign pos_in   = tab_addr < n_r;
  assign pos_x    = pos_in ? tab_x_r[tab_addr[IW-1:0]] : '0;
  assign pos_y    = pos_in ? tab_y_r[tab_addr[IW-1:0]] : '0;
  assign pos_v    = pos_in && tab_v_r[tab_addr[IW-1:0]];

  // shared multiplier
  logic signed [CW:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  always_comb begin
    case (ms_r)
      3'd0:    begin mul_a = dx_r; mul_b = dx_r; end
      3'd1:    begin mul_a = dy_r; mul_b = dy_r; end
      3'd2:    begin mul_a = qx_r; mul_b = dx_r; end
      3'd3:    begin mul_a = qy_r; mul_b = dy_r; end
      default: begin mul_a = '0;   mul_b = '0;   end
    endcase
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // shared restoring divider step
  logic [DW-1:0] rem2, rem_step;
  logic          div_ge;
  logic [16:0]   q_step;
  assign rem2     = {rem_r[DW-2:0], 1'b0};
  assign div_ge   = rem2 >= den_r;
  assign rem_step = div_ge ? rem2 - den_r : rem2;
  assign q_step   = {q_r[15:0], div_ge};

  // pair setup checks
  logic signed [AW-1:0] num;
  logic len_zero, num_le0, num_ge;
  assign num      = len_r - proj_r;
  assign len_zero = len_r == '0;
  assign num_le0  = num[AW-1] || (num == '0);
  assign num_ge   = num >= len_r;

  logic out_free, in_acc, k_listed, k_done, more_after, k_center;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_acc   = in_ch.valid && (state_r == ST_IDLE);
  assign k_done   = k_r >= end_r;
  assign k_listed = listed_r[k_r[SLW-1:0]];
  assign k_center = k_r >= n_r;

  always_comb begin
    more_after = 1'b0;
    for (int b = 0; b < SLOTS; b++) begin
      if (listed_r[b] && (SW'(b) > k_r)) more_after = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.op == OP_QUERY) begin
          state_nxt = (n_calc == SW'(1) && !ctr_en_r) ? ST_EONE : ST_OUTER;
        end
      end
      ST_OUTER: begin
        if (i_r >= end_r) state_nxt = (listed_r == '0) ? ST_EEMPTY : ST_NSCAN;
        else if (!(pos_in && !pos_v)) state_nxt = ST_PAIR;
      end
      ST_PAIR:  state_nxt = (j_r >= end_r) ? ST_FIN : ST_MUL;
      ST_MUL:   if (ms_r == 3'd4) state_nxt = ST_PSET;
      ST_PSET: begin
        state_nxt = (len_zero || num_le0 || num_ge) ? ST_PAIR : ST_PDIV;
      end
      ST_PDIV:  if (dcnt_r == 4'(DIV_STEPS - 1)) state_nxt = ST_PAIR;
      ST_FIN:   state_nxt = ST_OUTER;
      ST_NSCAN: begin
        if (k_done) state_nxt = ST_ESCAN;
        else if (k_listed) state_nxt = ST_NRD;
      end
      ST_NRD:   state_nxt = (SUMW'(rd_r) >= sum_r) ? ST_NSCAN : ST_NDIV;
      ST_NDIV:  if (dcnt_r == 4'(DIV_STEPS - 1)) state_nxt = ST_NSCAN;
      ST_ESCAN: begin
        if (k_done) state_nxt = ST_IDLE;
        else if (k_listed) state_nxt = ST_EOUT;
      end
      ST_EOUT:  if (out_free) state_nxt = more_after ? ST_ESCAN : ST_IDLE;
      ST_EONE, ST_EEMPTY: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [16:0] nv;
    logic        nv_set;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; n_nxt = n_r; end_nxt = end_r;
    px_nxt = px_r; py_nxt = py_r; pix_nxt = pix_r; piy_nxt = piy_r;
    qx_nxt = qx_r; qy_nxt = qy_r; dx_nxt = dx_r; dy_nxt = dy_r;
    ms_nxt = ms_r; prod_nxt = prod_r; len_nxt = len_r; proj_nxt = proj_r;
    w_nxt = w_r; sum_nxt = sum_r; listed_nxt = listed_r;
    rem_nxt = rem_r; den_nxt = den_r; q_nxt = q_r; dcnt_nxt = dcnt_r;
    best_nxt = best_r; best_v_nxt = best_v_r; best_w_nxt = best_w_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    raw_we = 1'b0; raw_wa = k_r[SLW-1:0]; raw_wd = '0;
    nv = '0; nv_set = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.op == OP_QUERY) begin
          px_nxt = in_ch.query_x;
          py_nxt = in_ch.query_y;
          n_nxt = n_calc;
          end_nxt = n_calc + SW'(ctr_en_r);
          i_nxt = '0;
          k_nxt = '0;
          sum_nxt = '0;
          listed_nxt = '0;
          best_v_nxt = 1'b0;
        end
      end
      ST_OUTER: begin
        pix_nxt = pos_x;
        piy_nxt = pos_y;
        qx_nxt = (CW+1)'(pos_x) - (CW+1)'(px_r);
        qy_nxt = (CW+1)'(pos_y) - (CW+1)'(py_r);
        w_nxt = ONE_Q16;
        j_nxt = '0;
        if (i_r < end_r && pos_in && !pos_v) i_nxt = i_r + SW'(1);
      end
      ST_PAIR: begin
        dx_nxt = (CW+1)'(pix_r) - (CW+1)'(pos_x);
        dy_nxt = (CW+1)'(piy_r) - (CW+1)'(pos_y);
        ms_nxt = '0;
      end
      ST_MUL: begin
        // product is registered, so each step uses the product of the step before
        prod_nxt = mul_p;
        ms_nxt = ms_r + 3'd1;
        case (ms_r)
          3'd1:    len_nxt = AW'(prod_r);
          3'd2:    len_nxt = len_r + AW'(prod_r);
          3'd3:    proj_nxt = AW'(prod_r);
          3'd4:    proj_nxt = proj_r + AW'(prod_r);
          default: ;
        endcase
      end
      ST_PSET: begin
        if (len_zero) begin
          j_nxt = j_r + SW'(1);
        end else if (num_le0) begin
          w_nxt = '0;
          j_nxt = j_r + SW'(1);
        end else if (num_ge) begin
          j_nxt = j_r + SW'(1);
        end else begin
          rem_nxt = DW'(num);
          den_nxt = DW'(len_r);
          q_nxt = '0;
          dcnt_nxt = '0;
        end
      end
      ST_PDIV: begin
        rem_nxt = rem_step;
        q_nxt = q_step;
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'(DIV_STEPS - 1)) begin
          if (q_step < w_r) w_nxt = q_step;
          j_nxt = j_r + SW'(1);
        end
      end
      ST_FIN: begin
        raw_we = 1'b1;
        raw_wa = i_r[SLW-1:0];
        raw_wd = w_r;
        if (w_r != '0) begin
          listed_nxt[i_r[SLW-1:0]] = 1'b1;
          sum_nxt = sum_r + SUMW'(w_r);
        end
        i_nxt = i_r + SW'(1);
      end
      ST_NSCAN: begin
        if (k_done) k_nxt = '0;
        else if (!k_listed) k_nxt = k_r + SW'(1);
      end
      ST_NRD: begin
        if (SUMW'(rd_r) >= sum_r) begin
          nv = ONE_Q16;
          nv_set = 1'b1;
        end else begin
          rem_nxt = DW'(rd_r);
          den_nxt = DW'(sum_r);
          q_nxt = '0;
          dcnt_nxt = '0;
        end
      end
      ST_NDIV: begin
        rem_nxt = rem_step;
        q_nxt = q_step;
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'(DIV_STEPS - 1)) begin
          nv = q_step;
          nv_set = 1'b1;
        end
      end
      ST_ESCAN: begin
        if (!k_done && !k_listed) k_nxt = k_r + SW'(1);
      end
      ST_EOUT: begin
        if (out_free) begin
          out_nxt.sample_index = k_center ? 3'd0 : 3'(k_r);
          out_nxt.is_center = k_center;
          out_nxt.weight = rd_r;
          out_nxt.is_max = k_r[SLW-1:0] == best_r;
          out_nxt.empty_res = 1'b0;
          out_nxt.last = !more_after;
          out_valid_nxt = 1'b1;
          k_nxt = k_r + SW'(1);
        end
      end
      ST_EONE: begin
        if (out_free) begin
          out_nxt = '{sample_index: 3'd0, is_center: 1'b0, weight: ONE_Q16,
                      is_max: 1'b1, empty_res: 1'b0, last: 1'b1};
          out_valid_nxt = 1'b1;
        end
      end
      ST_EEMPTY: begin
        if (out_free) begin
          out_nxt = '{sample_index: 3'd0, is_center: 1'b0, weight: '0,
                      is_max: 1'b0, empty_res: 1'b1, last: 1'b1};
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
    // normalized weight done: store over the raw weight, track first maximum
    if (nv_set) begin
      raw_we = 1'b1;
      raw_wa = k_r[SLW-1:0];
      raw_wd = nv;
      if (!best_v_r || nv > best_w_r) begin
        best_nxt = k_r[SLW-1:0];
        best_w_nxt = nv;
        best_v_nxt = 1'b1;
      end
      k_nxt = k_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      samp_cnt_r <= '0;
      ctr_en_r <= 1'b0;
      tab_v_r <= '0;
      for (int e = 0; e < MAX_SAMPLES; e++) begin
        tab_x_r[e] <= '0;
        tab_y_r[e] <= '0;
      end
      listed_r <= '0;
      best_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      listed_r <= listed_nxt;
      best_v_r <= best_v_nxt;
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_CENTER_ENABLE) ctr_en_r <= pwdata[0];
        else samp_cnt_r <= pwdata[3:0];
      end
      if (in_acc && in_ch.op == OP_WRITE &&
          (IW+3)'(in_ch.entry_index) < (IW+3)'(MAX_SAMPLES)) begin
        tab_x_r[IW'(in_ch.entry_index)] <= in_ch.entry_x;
        tab_y_r[IW'(in_ch.entry_index)] <= in_ch.entry_y;
        tab_v_r[IW'(in_ch.entry_index)] <= in_ch.entry_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; n_r <= n_nxt; end_r <= end_nxt;
    px_r <= px_nxt; py_r <= py_nxt; pix_r <= pix_nxt; piy_r <= piy_nxt;
    qx_r <= qx_nxt; qy_r <= qy_nxt; dx_r <= dx_nxt; dy_r <= dy_nxt;
    ms_r <= ms_nxt; prod_r <= prod_nxt; len_r <= len_nxt; proj_r <= proj_nxt;
    w_r <= w_nxt; sum_r <= sum_nxt;
    rem_r <= rem_nxt; den_r <= den_nxt; q_r <= q_nxt; dcnt_r <= dcnt_nxt;
    best_r <= best_nxt; best_w_r <= best_w_nxt;
    out_r <= out_nxt;
  end

  // weight store, registered read at the scan slot
  always_ff @(posedge clk) begin
    if (raw_we) raw_mem[raw_wa] <= raw_wd;
    rd_r <= raw_mem[k_r[SLW-1:0]];
  end

  assign in_ch.ready = state_r == ST_IDLE;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_index = out_r.sample_index;
  assign out_ch.is_center    = out_r.is_center;
  assign out_ch.weight       = out_r.weight;
  assign out_ch.is_max       = out_r.is_max;
  assign out_ch.empty_res    = out_r.empty_res;
  assign out_ch.last         = out_r.last;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CENTER_ENABLE) ? {31'b0, ctr_en_r} : {28'b0, samp_cnt_r};

endmodule
